// File: sv/arat_pkg.sv
package arat_pkg;

    localparam int SLOTS     = 64;
    localparam int ADDR_BITS = 48;
    localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_BITS  = SLOT_BITS + 1;
    localparam int ST_BITS   = 3;

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result codes
    localparam logic [ST_BITS-1:0] ST_OK        = 3'd0;
    localparam logic [ST_BITS-1:0] ST_START_OUT = 3'd1;
    localparam logic [ST_BITS-1:0] ST_END_OUT   = 3'd2;
    localparam logic [ST_BITS-1:0] ST_OVERLAP   = 3'd3;
    localparam logic [ST_BITS-1:0] ST_BAD_FREE  = 3'd4;
    localparam logic [ST_BITS-1:0] ST_FULL      = 3'd5;

    typedef logic [ADDR_BITS-1:0] t_addr;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // flags from the slot compare unit
    typedef struct packed {
        logic overlap;
        logic match;
    } t_cmp_flags;

endpackage

// File: sv/address_range_allocation_table_unit.sv
// Address range allocation table.
// Input channel (i_in_valid / o_in_ready) takes one request word: i_req_type
// (0 allocate, 1 free), i_address and i_length. Output channel
// (o_out_valid / i_out_ready) gives one o_status word per request.
// The arena size is written through i_cfg_we / i_cfg_wdata; the user must
// do so only while idle, as the block itself does not enforce it. Each
// request is checked against the arena first; then one compare unit walks
// the table one slot per cycle out of a registered-read RAM. A request that
// fails the arena check skips the scan, and a scan stops at the first
// overlap or free match. One request is worked at a time; o_in_ready is
// high only while the sequencer is idle. It returns in the cycle
// o_out_valid rises, so a new request is taken only once the last is done.
// The result sits in an output register, so the next request is accepted
// and worked while an earlier status waits; if the receiver stalls, a
// finished request holds in its last step until the register frees up.
// Reset clears the slot valid bits (empty table), the arena size and the
// output valid bit; the slot RAM itself is not cleared.
module address_range_allocation_table_unit
    import arat_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [ADDR_BITS-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_req_type,
    input  logic [ADDR_BITS-1:0] i_address,
    input  logic [ADDR_BITS-1:0] i_length,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [ST_BITS-1:0] o_status
);

    t_state               r_state, n_state;
    t_addr                r_arena;
    logic                 r_req_type;
    t_addr                r_addr;
    t_addr                r_len;
    logic [ST_BITS-1:0]   r_status, n_status;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic                 r_cmp_vld, n_cmp_vld;
    logic [SLOT_BITS-1:0] r_cmp_idx, n_cmp_idx;
    logic                 r_free_found, n_free_found;
    logic [SLOT_BITS-1:0] r_free_idx, n_free_idx;
    logic [SLOTS-1:0]     r_slot_valid, n_slot_valid;
    logic                 r_out_valid;
    logic [ST_BITS-1:0]   r_out_status;

    logic                     w_in_acc;
    logic                     w_out_load;
    logic                     w_ram_we;
    logic [SLOT_BITS-1:0]     w_ram_waddr;
    logic                     w_ram_re;
    logic [2*ADDR_BITS-1:0]   w_ram_rdata;
    t_addr                    w_slot_start;
    t_addr                    w_slot_len;
    t_cmp_flags               w_flags;
    logic                     w_slot_v;
    logic                     w_last;
    logic                     w_start_out;
    logic                     w_end_out;
    t_addr                    w_room;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // slot store: start in the upper half, length in the lower half
    arat_ram #(
        .WIDTH (2*ADDR_BITS),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata ({r_addr, r_len}),
        .i_re    (w_ram_re),
        .i_raddr (r_cnt[SLOT_BITS-1:0]),
        .o_rdata (w_ram_rdata)
    );

    assign w_slot_start = w_ram_rdata[2*ADDR_BITS-1:ADDR_BITS];
    assign w_slot_len   = w_ram_rdata[ADDR_BITS-1:0];

    arat_cmp u_cmp (
        .i_req_addr   (r_addr),
        .i_req_len    (r_len),
        .i_slot_start (w_slot_start),
        .i_slot_len   (w_slot_len),
        .o_flags      (w_flags)
    );

    // arena checks, done once per request
    assign w_room      = r_arena - r_addr;
    assign w_start_out = (r_addr >= r_arena);
    assign w_end_out   = (r_len == '0) || (r_len > w_room);

    assign w_slot_v = r_slot_valid[r_cmp_idx];
    assign w_last   = (r_cmp_idx == SLOT_BITS'(SLOTS - 1));

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        n_cnt        = r_cnt;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_slot_valid = r_slot_valid;
        w_ram_we     = 1'b0;
        w_ram_waddr  = r_free_idx;
        w_ram_re     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_cnt        = '0;
                n_free_found = 1'b0;
                n_state      = S_SCAN;
                if (r_req_type == REQ_ALLOC) begin
                    if (w_start_out) begin
                        n_status = ST_START_OUT;
                        n_state  = S_DONE;
                    end else if (w_end_out) begin
                        n_status = ST_END_OUT;
                        n_state  = S_DONE;
                    end
                end else if (r_addr > r_arena) begin
                    n_status = ST_BAD_FREE;
                    n_state  = S_DONE;
                end
            end
            S_SCAN: begin
                // issue the next slot read
                if (r_cnt < CNT_BITS'(SLOTS)) begin
                    w_ram_re  = 1'b1;
                    n_cnt     = r_cnt + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_cnt[SLOT_BITS-1:0];
                end
                // judge the slot read in the previous cycle
                if (r_cmp_vld) begin
                    if (r_req_type == REQ_FREE) begin
                        if (w_slot_v && w_flags.match) begin
                            n_slot_valid[r_cmp_idx] = 1'b0;
                            n_status = ST_OK;
                            n_state  = S_DONE;
                        end else if (w_last) begin
                            n_status = ST_BAD_FREE;
                            n_state  = S_DONE;
                        end
                    end else if (w_slot_v && w_flags.overlap) begin
                        n_status = ST_OVERLAP;
                        n_state  = S_DONE;
                    end else begin
                        if (!w_slot_v && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_cmp_idx;
                        end
                        if (w_last) begin
                            n_state = S_DONE;
                            if (n_free_found) begin
                                w_ram_we    = 1'b1;
                                w_ram_waddr = n_free_idx;
                                n_slot_valid[n_free_idx] = 1'b1;
                                n_status = ST_OK;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                    end
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_arena      <= '0;
            r_slot_valid <= '0;
            r_cmp_vld    <= 1'b0;
            r_free_found <= 1'b0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot_valid <= n_slot_valid;
            r_cmp_vld    <= n_cmp_vld;
            r_free_found <= n_free_found;
            r_cnt        <= n_cnt;
            if (i_cfg_we) begin
                r_arena <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req_type <= i_req_type;
            r_addr     <= i_address;
            r_len      <= i_length;
        end
        r_status   <= n_status;
        r_cmp_idx  <= n_cmp_idx;
        r_free_idx <= n_free_idx;
        if (w_out_load) begin
            r_out_status <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;

endmodule

// File: sv/arat_ram.sv
module arat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/arat_cmp.sv
module arat_cmp
    import arat_pkg::*;
(
    input  t_addr      i_req_addr,
    input  t_addr      i_req_len,
    input  t_addr      i_slot_start,
    input  t_addr      i_slot_len,
    output t_cmp_flags o_flags
);

    t_addr w_d_req;
    t_addr w_d_slot;

    // half-open ranges overlap when either start falls inside the other range
    assign w_d_req  = i_req_addr - i_slot_start;
    assign w_d_slot = i_slot_start - i_req_addr;

    assign o_flags.overlap = (w_d_req < i_slot_len) || (w_d_slot < i_req_len);
    assign o_flags.match   = (i_slot_start == i_req_addr);

endmodule

// File: sv/arat_checker.sv
module arat_checker
    import arat_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [ST_BITS-1:0] o_status
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("stalled result word changed or dropped");

    // status is always a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_FULL))
        else $error("undefined status code");

    // busy right after taking a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready while a request is in work");

    // a new result appears only as the sequencer goes idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result issued while still busy");

    // reset leaves the block idle and empty
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("not idle after reset");

endmodule

bind address_range_allocation_table_unit arat_checker u_arat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status)
);
